// File: sv/omni_wheel_joystick_mixer_defines.svh
// ----------------------------------------------------------------------------
// omni_wheel_joystick_mixer_defines
// Assertion macros shared by the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_JOYSTICK_MIXER_DEFINES_SVH
`define OMNI_WHEEL_JOYSTICK_MIXER_DEFINES_SVH

// same-cycle implication
`define OWJM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("owjm assertion failed");

// next-cycle implication
`define OWJM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("owjm assertion failed");

`endif

// File: sv/owjm_pkg.sv
// ----------------------------------------------------------------------------
// owjm_pkg
// Types and constants of the omni wheel joystick mixer.
// ----------------------------------------------------------------------------
package owjm_pkg;

    localparam int unsigned VW = 19;   // CORDIC stick vector
    localparam int unsigned RW = 34;   // Q2.30 rotation vector
    localparam int unsigned BW = 18;   // multiplier second operand
    localparam int unsigned PW = RW + BW;
    localparam int unsigned QW = 20;   // truncated quotient

    localparam logic signed [RW-1:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [BW-1:0] INV_SQRT2_Q15 = 18'sd23170;
    localparam logic signed [17:0]   TRIG_MIN      = 18'sd19661;

    typedef logic [1:0] t_sh;
    localparam t_sh SH_Q30 = 2'd0;
    localparam t_sh SH_Q16 = 2'd1;
    localparam t_sh SH_Q15 = 2'd2;

    typedef struct packed {
        logic       vld;
        logic [3:0] tag;
        t_sh        sh;
    } t_mul_req;

    typedef struct packed {
        logic       vld;
        logic [3:0] tag;
    } t_mul_rsp;

    typedef struct packed {
        logic done;
        logic flip;
    } t_cordic_stat;

endpackage

// File: sv/owjm_cordic.sv
// ----------------------------------------------------------------------------
// owjm_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle; yields cos/sin
// of the stick angle in Q2.30 (before the pi flip, reported in status).
// ----------------------------------------------------------------------------
module owjm_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [16:0]                 i_x,
    input  logic signed [16:0]                 i_y,
    output logic signed [owjm_pkg::RW-1:0]     o_c,
    output logic signed [owjm_pkg::RW-1:0]     o_s,
    output owjm_pkg::t_cordic_stat             o_stat
);
    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [owjm_pkg::VW-1:0] r_vx, r_vy;
    logic signed [owjm_pkg::RW-1:0] r_rx, r_ry;
    logic [IW-1:0]                  r_i;
    logic                           r_busy, r_done, r_flip;

    logic signed [owjm_pkg::VW-1:0] w_x0, w_y0, w_dvx, w_dvy;
    logic signed [owjm_pkg::RW-1:0] w_erx, w_ery;
    logic                           w_zero, w_neg;

    always_comb begin
        w_zero = (i_x == 17'sd0) && (i_y == 17'sd0);
        w_neg  = i_x[16];
        w_x0   = w_neg ? -(owjm_pkg::VW)'(i_x) : (owjm_pkg::VW)'(i_x);
        w_y0   = w_neg ? -(owjm_pkg::VW)'(i_y) : (owjm_pkg::VW)'(i_y);
        w_dvx  = r_vy >>> r_i;
        w_dvy  = r_vx >>> r_i;
        w_erx  = r_ry >>> r_i;
        w_ery  = r_rx >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_flip <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (w_zero) begin
                    r_rx   <= owjm_pkg::ONE_Q30;
                    r_ry   <= '0;
                    r_flip <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_vx   <= w_x0;
                    r_vy   <= w_y0;
                    r_rx   <= owjm_pkg::INV_GAIN_Q30;
                    r_ry   <= '0;
                    r_flip <= w_neg;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (!r_vy[owjm_pkg::VW-1]) begin
                    r_vx <= r_vx + w_dvx;
                    r_vy <= r_vy - w_dvy;
                    r_rx <= r_rx - w_erx;
                    r_ry <= r_ry + w_ery;
                end else begin
                    r_vx <= r_vx - w_dvx;
                    r_vy <= r_vy + w_dvy;
                    r_rx <= r_rx + w_erx;
                    r_ry <= r_ry - w_ery;
                end
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_c         = r_rx;
    assign o_s         = r_ry;
    assign o_stat.done = r_done;
    assign o_stat.flip = r_flip;

endmodule

// File: sv/owjm_mul.sv
// ----------------------------------------------------------------------------
// owjm_mul
// Shared signed multiplier with registered product and a truncating
// (toward zero) right shift by 30, 16 or 15.
// ----------------------------------------------------------------------------
module owjm_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  owjm_pkg::t_mul_req                 i_req,
    input  logic signed [owjm_pkg::RW-1:0]     i_a,
    input  logic signed [owjm_pkg::BW-1:0]     i_b,
    output owjm_pkg::t_mul_rsp                 o_rsp,
    output logic signed [owjm_pkg::QW-1:0]     o_q
);
    logic signed [owjm_pkg::PW-1:0] r_prod;
    owjm_pkg::t_sh                  r_sh;
    logic                           r_vld;
    logic [3:0]                     r_tag;

    logic signed [owjm_pkg::PW-1:0] w_bias, w_sum, w_shf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req.vld;
        end
        r_prod <= i_a * i_b;
        r_sh   <= i_req.sh;
        r_tag  <= i_req.tag;
    end

    always_comb begin
        unique case (r_sh)
            owjm_pkg::SH_Q30: w_bias = (owjm_pkg::PW)'((64'd1 << 30) - 64'd1);
            owjm_pkg::SH_Q16: w_bias = (owjm_pkg::PW)'((64'd1 << 16) - 64'd1);
            owjm_pkg::SH_Q15: w_bias = (owjm_pkg::PW)'((64'd1 << 15) - 64'd1);
            default:          w_bias = '0;
        endcase
        w_sum = r_prod + (r_prod[owjm_pkg::PW-1] ? w_bias : '0);
        unique case (r_sh)
            owjm_pkg::SH_Q30: w_shf = w_sum >>> 30;
            owjm_pkg::SH_Q16: w_shf = w_sum >>> 16;
            owjm_pkg::SH_Q15: w_shf = w_sum >>> 15;
            default:          w_shf = w_sum;
        endcase
    end

    assign o_q       = w_shf[owjm_pkg::QW-1:0];
    assign o_rsp.vld = r_vld;
    assign o_rsp.tag = r_tag;

endmodule

// File: sv/omni_wheel_joystick_mixer.sv
// ----------------------------------------------------------------------------
// omni_wheel_joystick_mixer
// Four-wheel omni drive mixer: one gamepad sample in, four wheel duties out.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    sticks, trigger, buttons
//  m_axis    out  m_axis_tvalid/m_axis_tready    four wheel duties
//  cfg       in   i_cfg_we                       duty_scale, yaw_speed, dead_zone
//
// Trigger sample: the CORDIC loop (skipped with a centred stick), then
// twelve beats through the shared multiplier.
// Other samples: four duty beats through the shared multiplier.
// s_axis_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next sample is taken
// meanwhile and its result waits until that register is free.
// Reset (synchronous, active low) restores config defaults, zero wheel speeds.
// ----------------------------------------------------------------------------
`include "omni_wheel_joystick_mixer_defines.svh"

module omni_wheel_joystick_mixer #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lsb up: left_stick_x[16], left_stick_y[16], right_stick_x[16],
    // right_stick_y[16], trigger_axis[16], yaw_left_button, yaw_right_button,
    // 6 zero bits
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lsb up: wheel_one_duty[11], wheel_two_duty[11], wheel_three_duty[11],
    // wheel_four_duty[11], 4 zero bits
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORD = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] CFG_DUTY = 2'd0;
    localparam logic [1:0] CFG_YAW  = 2'd1;
    localparam logic [1:0] CFG_DZ   = 2'd2;

    localparam logic [3:0] OP_P0   = 4'd0;
    localparam logic [3:0] OP_D0   = 4'd8;
    localparam logic [3:0] OP_LAST = 4'd11;
    localparam logic [3:0] OP_END  = 4'd12;

    localparam logic [1:0] GRP_P = 2'd0;
    localparam logic [1:0] GRP_V = 2'd1;
    localparam logic [1:0] GRP_D = 2'd2;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_k, n_k;
    logic [9:0]  r_ds;
    logic [14:0] r_yaw, r_dz;
    logic signed [17:0] r_m;
    logic signed [owjm_pkg::RW-1:0] r_sum, r_dif;
    logic signed [15:0] r_ws   [4];
    logic signed [17:0] r_p    [4];
    logic signed [10:0] r_duty [4];
    logic [43:0] r_odata;
    logic        r_ovalid;

    logic        w_acc, w_trig, w_yr, w_yl, w_dead, w_load;
    logic signed [16:0] w_lx, w_ly, w_rx, w_ry, w_dzs;
    logic signed [16:0] w_alx, w_aly, w_arx, w_ary;
    logic signed [17:0] w_m;
    logic signed [15:0] w_yaw;
    logic signed [owjm_pkg::RW-1:0] w_c, w_s, w_a;
    logic signed [owjm_pkg::BW-1:0] w_b;
    owjm_pkg::t_cordic_stat w_cst;
    owjm_pkg::t_mul_req     w_req;
    owjm_pkg::t_mul_rsp     w_rsp;
    logic signed [owjm_pkg::QW-1:0] w_q;
    logic signed [15:0] w_sat;
    logic [1:0]  w_w;
    logic        w_nb;

    // input decode
    always_comb begin
        w_lx  = 17'sd0 - {s_axis_tdata[15], s_axis_tdata[15:0]};
        w_ly  = {s_axis_tdata[31], s_axis_tdata[31:16]};
        w_rx  = 17'sd0 - {s_axis_tdata[47], s_axis_tdata[47:32]};
        w_ry  = {s_axis_tdata[63], s_axis_tdata[63:48]};
        w_m   = 18'sd32768 - {{2{s_axis_tdata[79]}}, s_axis_tdata[79:64]};
        w_dzs = {2'b00, r_dz};
        w_alx = w_lx[16] ? -w_lx : w_lx;
        w_aly = w_ly[16] ? -w_ly : w_ly;
        w_arx = w_rx[16] ? -w_rx : w_rx;
        w_ary = w_ry[16] ? -w_ry : w_ry;
        w_trig = w_m >= owjm_pkg::TRIG_MIN;
        w_yr   = (w_rx >= w_dzs) || s_axis_tdata[81];
        w_yl   = (w_rx <= -w_dzs) || s_axis_tdata[80];
        w_dead = (w_alx <= w_dzs) && (w_aly <= w_dzs) &&
                 (w_arx <= w_dzs) && (w_ary <= w_dzs);
        w_yaw  = {1'b0, r_yaw};
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    owjm_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc && w_trig),
        .i_x     (w_lx),
        .i_y     (w_ly),
        .o_c     (w_c),
        .o_s     (w_s),
        .o_stat  (w_cst)
    );

    // operand select for the shared multiplier
    always_comb begin
        w_w     = r_k[1:0];
        w_nb    = ((w_w == 2'd0) || (w_w == 2'd3)) ^ w_cst.flip;
        w_req   = '0;
        w_a     = '0;
        w_b     = '0;
        w_req.vld = (r_state == S_MUL) && (r_k < OP_END);
        w_req.tag = r_k;
        unique case (r_k[3:2])
            GRP_P: begin
                w_a = w_w[0] ? r_dif : r_sum;
                w_b = w_nb ? -owjm_pkg::INV_SQRT2_Q15 : owjm_pkg::INV_SQRT2_Q15;
                w_req.sh = owjm_pkg::SH_Q30;
            end
            GRP_V: begin
                w_a = (owjm_pkg::RW)'(r_p[w_w]);
                w_b = r_m;
                w_req.sh = owjm_pkg::SH_Q16;
            end
            GRP_D: begin
                w_a = (owjm_pkg::RW)'(r_ws[w_w]);
                w_b = {8'b0, r_ds};
                w_req.sh = owjm_pkg::SH_Q15;
            end
            default: begin
                w_req.vld = 1'b0;
            end
        endcase
    end

    owjm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_q     (w_q)
    );

    always_comb begin
        if (w_q > 20'sd32767) begin
            w_sat = 16'sd32767;
        end else if (w_q < -20'sd32768) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_q[15:0];
        end
    end

    assign w_load = !r_ovalid || m_axis_tready;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = w_trig ? S_CORD : S_MUL;
                    n_k     = w_trig ? OP_P0 : OP_D0;
                end
            end
            S_CORD: begin
                if (w_cst.done) n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_k < OP_END) n_k = r_k + 4'd1;
                if (w_rsp.vld && (w_rsp.tag == OP_LAST)) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= OP_P0;
            r_ovalid <= 1'b0;
            r_ds     <= 10'd500;
            r_yaw    <= 15'd16384;
            r_dz     <= 15'd9830;
            for (int i = 0; i < 4; i++) r_ws[i] <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DUTY: r_ds  <= i_cfg_data[9:0];
                    CFG_YAW:  r_yaw <= i_cfg_data;
                    CFG_DZ:   r_dz  <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (w_acc && !w_trig) begin
                for (int i = 0; i < 4; i++) begin
                    if (w_yr) begin
                        r_ws[i] <= -w_yaw;
                    end else if (w_yl) begin
                        r_ws[i] <= w_yaw;
                    end else if (w_dead) begin
                        r_ws[i] <= '0;
                    end
                end
            end
            if (w_rsp.vld && (w_rsp.tag[3:2] == GRP_V)) r_ws[w_rsp.tag[1:0]] <= w_sat;
            if ((r_state == S_OUT) && w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) r_m <= w_m;
        if (r_state == S_SUM) begin
            r_sum <= w_c + w_s;
            r_dif <= w_c - w_s;
        end
        if (w_rsp.vld && (w_rsp.tag[3:2] == GRP_P)) r_p[w_rsp.tag[1:0]] <= w_q[17:0];
        if (w_rsp.vld && (w_rsp.tag[3:2] == GRP_D)) r_duty[w_rsp.tag[1:0]] <= w_q[10:0];
        if ((r_state == S_OUT) && w_load) begin
            r_odata <= {r_duty[3], r_duty[2], r_duty[1], r_duty[0]};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_odata};

    `OWJM_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, w_acc, r_state != S_IDLE)
    `OWJM_ASSERT_IMP(a_rsp_in_mul, i_clk, i_rst_n, w_rsp.vld, r_state == S_MUL)
    `OWJM_ASSERT_IMP(a_done_in_cord, i_clk, i_rst_n, w_cst.done, r_state == S_CORD)
    `OWJM_ASSERT_IMP(a_cord_k, i_clk, i_rst_n, r_state == S_CORD, r_k == OP_P0)

endmodule

// File: verif/omni_wheel_joystick_mixer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// omni_wheel_joystick_mixer_check
// Watches the sample, duty and register channels of the mixer. Keeps its own
// copy of the registers and wheel speeds, predicts the four duties of every
// accepted sample and compares each duty beat with the oldest prediction.
// ----------------------------------------------------------------------------
package owjm_test_pkg;

    localparam logic [1:0] REG_DUTY_SCALE = 2'd0;
    localparam logic [1:0] REG_YAW_SPEED  = 2'd1;
    localparam logic [1:0] REG_DEAD_ZONE  = 2'd2;
    localparam logic [1:0] REG_SPARE      = 2'd3;

    typedef struct packed {
        logic [5:0]         pad;
        logic               yaw_right;
        logic               yaw_left;
        logic signed [15:0] trigger;
        logic signed [15:0] right_y;
        logic signed [15:0] right_x;
        logic signed [15:0] left_y;
        logic signed [15:0] left_x;
    } t_gamepad;

    // [0] is wheel one, lowest bits
    typedef logic [3:0][10:0] t_duties;

endpackage

module omni_wheel_joystick_mixer_check #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam longint UNIT_Q30       = 64'sd1073741824;
    localparam longint GAIN_COMP_Q30  = 64'sd652032874;
    localparam longint HALF_ROOT2_Q15 = 64'sd23170;
    localparam longint TRIGGER_ON     = 64'sd19661;

    logic [9:0]  duty_scale = 10'd500;
    logic [14:0] yaw_speed  = 15'd16384;
    logic [14:0] dead_zone  = 15'd9830;
    longint      wheel_speed [4];
    owjm_test_pkg::t_duties duty_queue [$];
    int          mismatches = 0;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // cos/sin of the stick angle in Q2.30, vectoring CORDIC driving a unit vector
    function automatic void stick_direction(input longint x, input longint y,
                                            output longint c, output longint s);
        longint vx, vy, rx, ry, dx, dy, ex, ey, t;
        bit     flip;
        int     i;
        if (x == 0 && y == 0) begin
            c = UNIT_Q30;
            s = 0;
            return;
        end
        vx   = x;
        vy   = y;
        rx   = GAIN_COMP_Q30;
        ry   = 0;
        flip = 1'b0;
        if (vx < 0) begin
            vx   = -vx;
            vy   = -vy;
            flip = 1'b1;
        end
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            ex = ry >>> i;
            ey = rx >>> i;
            if (vy >= 0) begin
                vx = vx + dx;
                vy = vy - dy;
                t  = rx - ex;
                ry = ry + ey;
                rx = t;
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                t  = rx + ex;
                ry = ry - ey;
                rx = t;
            end
        end
        if (flip) begin
            rx = -rx;
            ry = -ry;
        end
        c = rx;
        s = ry;
    endfunction

    function automatic longint wheel_q15(input longint combo, input longint amount);
        longint p, v;
        p = (combo * HALF_ROOT2_Q15) / UNIT_Q30;
        v = (p * amount) / 65536;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic owjm_test_pkg::t_duties next_duties(input owjm_test_pkg::t_gamepad g);
        longint  lx, ly, rx, ry, amount, dz, c, s, duty;
        owjm_test_pkg::t_duties d;
        int      i;
        lx     = -longint'($signed(g.left_x));
        ly     = longint'($signed(g.left_y));
        rx     = -longint'($signed(g.right_x));
        ry     = longint'($signed(g.right_y));
        amount = 32768 - longint'($signed(g.trigger));
        dz     = longint'(dead_zone);
        if (amount >= TRIGGER_ON) begin
            stick_direction(lx, ly, c, s);
            wheel_speed[0] = wheel_q15(-(s + c), amount);
            wheel_speed[1] = wheel_q15(c - s, amount);
            wheel_speed[2] = wheel_q15(s + c, amount);
            wheel_speed[3] = wheel_q15(s - c, amount);
        end else if (rx >= dz || g.yaw_right) begin
            for (i = 0; i < 4; i++) wheel_speed[i] = -longint'(yaw_speed);
        end else if (rx <= -dz || g.yaw_left) begin
            for (i = 0; i < 4; i++) wheel_speed[i] = longint'(yaw_speed);
        end else if (mag(lx) <= dz && mag(ly) <= dz && mag(rx) <= dz && mag(ry) <= dz) begin
            for (i = 0; i < 4; i++) wheel_speed[i] = 0;
        end
        for (i = 0; i < 4; i++) begin
            duty = (wheel_speed[i] * longint'(duty_scale)) / 32768;
            d[i] = duty[10:0];
        end
        return d;
    endfunction

    always @(posedge i_clk) begin : watch
        owjm_test_pkg::t_duties expected;
        owjm_test_pkg::t_duties got;
        got = m_axis_tdata[43:0];
        if (!i_rst_n) begin
            duty_scale = 10'd500;
            yaw_speed  = 15'd16384;
            dead_zone  = 15'd9830;
            for (int i = 0; i < 4; i++) wheel_speed[i] = 0;
            duty_queue.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (duty_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("duty beat with no sample pending: got %0d %0d %0d %0d",
                                 $signed(got[0]), $signed(got[1]),
                                 $signed(got[2]), $signed(got[3]));
                    mismatches++;
                end else begin
                    expected = duty_queue.pop_front();
                    if (got !== expected) begin
                        if (mismatches < 10)
                            $display("duty mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     $signed(expected[0]), $signed(expected[1]),
                                     $signed(expected[2]), $signed(expected[3]),
                                     $signed(got[0]), $signed(got[1]),
                                     $signed(got[2]), $signed(got[3]));
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    owjm_test_pkg::REG_DUTY_SCALE: duty_scale = i_cfg_data[9:0];
                    owjm_test_pkg::REG_YAW_SPEED:  yaw_speed  = i_cfg_data;
                    owjm_test_pkg::REG_DEAD_ZONE:  dead_zone  = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                duty_queue = {duty_queue, next_duties(s_axis_tdata)};
        end
        o_pending    <= duty_queue.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/omni_wheel_joystick_mixer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// omni_wheel_joystick_mixer_test
// Drives gamepad samples and register writes into the mixer with random
// stalls on both streams, none in the last phase: directed corner samples,
// then phases of random samples under several register settings. The
// checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module omni_wheel_joystick_mixer_test;

    localparam int CORDIC_STEPS  = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_SAMPLES = 235;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = owjm_test_pkg::REG_DUTY_SCALE;
    logic [14:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    bit gaps_on       = 1'b1;
    int cur_dead_zone = 9830;
    int ready_hold    = 0;

    omni_wheel_joystick_mixer #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    omni_wheel_joystick_mixer_check #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    always @(negedge i_clk) begin
        if (gaps_on && ready_hold == 0 && $urandom_range(0, 5) == 0)
            ready_hold = $urandom_range(1, 8);
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic owjm_test_pkg::t_gamepad make_sample(input int lsx, input int lsy,
                                                            input int rsx, input int rsy,
                                                            input int trig,
                                                            input bit yl, input bit yr);
        owjm_test_pkg::t_gamepad g;
        g.pad       = '0;
        g.left_x    = 16'(lsx);
        g.left_y    = 16'(lsy);
        g.right_x   = 16'(rsx);
        g.right_y   = 16'(rsy);
        g.trigger   = 16'(trig);
        g.yaw_left  = yl;
        g.yaw_right = yr;
        return g;
    endfunction

    function automatic int near_zero(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int beyond(input int lim);
        int m;
        m = int'($urandom_range(lim + 1, 32768));
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic owjm_test_pkg::t_gamepad random_sample();
        owjm_test_pkg::t_gamepad g;
        int       dz;
        int       pick;
        dz = cur_dead_zone;
        g  = make_sample(int'($urandom()), int'($urandom()), int'($urandom()),
                         int'($urandom()), int'($urandom()),
                         $urandom_range(0, 1), $urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                g.trigger = 16'(int'($urandom_range(0, 45875)) - 32768);
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                    g.left_x = '0;
                    g.left_y = '0;
                end else if (pick == 1) begin
                    g.left_x = 16'(near_zero(64));
                    g.left_y = 16'(near_zero(64));
                end
            end
            4, 5: begin
                g.trigger = 16'($urandom_range(13108, 32767));
                case ($urandom_range(0, 2))
                    0: g.yaw_right = 1'b1;
                    1: begin
                        g.yaw_left  = 1'b1;
                        g.yaw_right = 1'b0;
                    end
                    default: begin
                        g.yaw_left  = 1'b0;
                        g.yaw_right = 1'b0;
                        g.right_x   = 16'(beyond(dz));
                    end
                endcase
            end
            6, 7: begin
                g = make_sample(near_zero(dz), near_zero(dz), near_zero(dz), near_zero(dz),
                                $urandom_range(13108, 32767), 1'b0, 1'b0);
            end
            8: begin
                g = make_sample(near_zero(dz), near_zero(dz),
                                (dz > 0) ? near_zero(dz - 1) : 0,
                                near_zero(dz), $urandom_range(13108, 32767), 1'b0, 1'b0);
                case ($urandom_range(0, 2))
                    0: g.left_x  = 16'(beyond(dz));
                    1: g.left_y  = 16'(beyond(dz));
                    default: g.right_y = 16'(beyond(dz));
                endcase
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic send_sample(input owjm_test_pkg::t_gamepad g);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= g;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic apply_settings(input int ds, input int ys, input int dz);
        cur_dead_zone = dz & 32'h7fff;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= owjm_test_pkg::REG_DUTY_SCALE;
        i_cfg_data <= 15'(ds);
        @(negedge i_clk);
        i_cfg_idx  <= owjm_test_pkg::REG_YAW_SPEED;
        i_cfg_data <= 15'(ys);
        @(negedge i_clk);
        i_cfg_idx  <= owjm_test_pkg::REG_DEAD_ZONE;
        i_cfg_data <= 15'(dz);
        @(negedge i_clk);
        i_cfg_idx  <= owjm_test_pkg::REG_SPARE;
        i_cfg_data <= 15'($urandom());
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int ds, ys, dz;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: deadzone 9830
        send_sample(make_sample(0, 0, 0, 0, 32767, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, -32768, 0, 0));
        send_sample(make_sample(-32768, 0, 0, 0, -32767, 0, 0));
        send_sample(make_sample(32767, 0, 0, 0, -32768, 0, 0));
        send_sample(make_sample(0, 32767, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, -32768, 0, 0, -32768, 0, 0));
        send_sample(make_sample(12345, -23456, 0, 0, 13107, 0, 0));
        send_sample(make_sample(12345, -23456, 0, 0, 13108, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 32767, 0, 1));
        send_sample(make_sample(0, 0, 0, 0, 32767, 1, 0));
        send_sample(make_sample(0, 0, 0, 0, 32767, 1, 1));
        send_sample(make_sample(0, 0, -9830, 0, 32767, 0, 0));
        send_sample(make_sample(0, 0, 9830, 0, 32767, 0, 0));
        send_sample(make_sample(0, 0, -9829, 0, 32767, 0, 0));
        send_sample(make_sample(0, 0, -32768, 0, 32767, 0, 0));
        send_sample(make_sample(20000, 0, 0, 0, 32767, 0, 0));
        send_sample(make_sample(0, 0, 0, -32768, 32767, 0, 0));
        send_sample(make_sample(9830, -9830, 9829, 9830, 32767, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 32767, -32768, 1, 1));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32767, 0, 0));
        send_sample(make_sample(1, 0, 0, 0, -32768, 0, 0));
        send_sample(make_sample(0, -1, 0, 0, -32768, 0, 0));
        s_axis_tvalid <= 1'b0;
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin ds = 1000;   ys = 32767; dz = 0;     end
                1: begin ds = 0;      ys = 0;     dz = 32767; end
                2: begin ds = 'h7fff; ys = 1;     dz = 1;     end
                3: begin ds = 1;      ys = 32767; dz = 32767; end
                4: begin ds = 500;    ys = 16384; dz = 9830;  end
                6: begin
                    ds = int'($urandom_range(0, 32767));
                    ys = int'($urandom_range(0, 32767));
                    dz = int'($urandom_range(0, 32767));
                end
                default: begin
                    ds = int'($urandom_range(0, 1000));
                    ys = int'($urandom_range(0, 32767));
                    dz = int'($urandom_range(0, 32767));
                end
            endcase
            apply_settings(ds, ys, dz);
            gaps_on = (phase != PHASES - 1);
            repeat (PHASE_SAMPLES) send_sample(random_sample());
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end

        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
